// ----- hdl/dotted_line_pixel_generator_top_macros.svh -----
// Assertion macros for the dotted line pixel generator.
`ifndef DOTTED_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define DOTTED_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DLPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the enable argument is low.
`define DLPG_ASSERT_NEXT(label, clk, en, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(en)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/dlpg_pkg.sv -----
package dlpg_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int WIDTH_BITS     = 8;
    localparam int COLOR_BITS     = 8;
    localparam int DOT_BITS       = 10;
    localparam int DOT_RUN        = 3;
    localparam int DOT_GAP        = 4;
    localparam int DISP_W_RST     = 880;
    localparam int DISP_H_RST     = 528;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam int   CFG_IDX_BITS   = 1;
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [1:0] ST_PIXEL  = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       plot;
        logic       last;
    } t_res_ctl;

endpackage

// ----- hdl/dotted_line_pixel_generator_top.sv -----
// Path: an input transfer passes the input register, then the result register.
// Throughput: one item per cycle unless output stalls; one add-compare pass per step.
// A stalled output lets one more transfer into the input register before the input stalls.
// Reset (synchronous, active low) empties both registers, drops any line in progress
// and loads display width 880 and height 528. Configuration writes are taken every cycle.
`include "dotted_line_pixel_generator_top_macros.svh"

module dotted_line_pixel_generator_top #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [COORD_BITS-1:0]             i_start_x,
    input  logic [COORD_BITS-1:0]             i_start_y,
    input  logic [COORD_BITS-1:0]             i_end_x,
    input  logic [COORD_BITS-1:0]             i_end_y,
    input  logic [dlpg_pkg::COLOR_BITS-1:0]   i_pen_color,
    input  logic [dlpg_pkg::WIDTH_BITS-1:0]   i_pen_width,
    input  logic                              i_dotted,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [COORD_BITS-1:0]             o_pixel_x,
    output logic [COORD_BITS-1:0]             o_pixel_y,
    output logic                              o_plot,
    output logic [dlpg_pkg::WIDTH_BITS-1:0]   o_dot_size,
    output logic [dlpg_pkg::COLOR_BITS-1:0]   o_out_color,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dlpg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]             i_cfg_data
);
    import dlpg_pkg::*;

    logic                  w_s1_valid;
    logic                  w_take;
    logic                  w_func;
    logic [COORD_BITS-1:0] w_start_x, w_start_y, w_end_x, w_end_y;
    logic [COLOR_BITS-1:0] w_pen_color;
    logic [WIDTH_BITS-1:0] w_pen_width;
    logic                  w_dotted;
    t_res_ctl              w_ctl;
    logic [COORD_BITS-1:0] w_pixel_x, w_pixel_y;
    logic [WIDTH_BITS-1:0] w_dot_size;
    logic [COLOR_BITS-1:0] w_out_color;

    assign o_cfg_ready = 1'b1;

    dlpg_in_stage #(.COORD_BITS(COORD_BITS)) u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_func      (i_func),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_pen_color (i_pen_color),
        .i_pen_width (i_pen_width),
        .i_dotted    (i_dotted),
        .i_take      (w_take),
        .o_valid     (w_s1_valid),
        .o_func      (w_func),
        .o_start_x   (w_start_x),
        .o_start_y   (w_start_y),
        .o_end_x     (w_end_x),
        .o_end_y     (w_end_y),
        .o_pen_color (w_pen_color),
        .o_pen_width (w_pen_width),
        .o_dotted    (w_dotted)
    );

    dlpg_core #(.COORD_BITS(COORD_BITS)) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_take        (w_take),
        .i_func        (w_func),
        .i_start_x     (w_start_x),
        .i_start_y     (w_start_y),
        .i_end_x       (w_end_x),
        .i_end_y       (w_end_y),
        .i_pen_color   (w_pen_color),
        .i_pen_width   (w_pen_width),
        .i_dotted      (w_dotted),
        .o_ctl         (w_ctl),
        .o_pixel_x     (w_pixel_x),
        .o_pixel_y     (w_pixel_y),
        .o_dot_size    (w_dot_size),
        .o_out_color   (w_out_color)
    );

    dlpg_out_stage #(.COORD_BITS(COORD_BITS)) u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_s1_valid),
        .o_take        (w_take),
        .i_ctl         (w_ctl),
        .i_pixel_x     (w_pixel_x),
        .i_pixel_y     (w_pixel_y),
        .i_dot_size    (w_dot_size),
        .i_out_color   (w_out_color),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_status      (o_status),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_plot        (o_plot),
        .o_dot_size    (o_dot_size),
        .o_out_color   (o_out_color),
        .o_last        (o_last)
    );

    `DLPG_ASSERT_NOW(a_take_needs_item, i_clk, i_rst_n, w_take, w_s1_valid, "transfer to output with empty input register")
    `DLPG_ASSERT_NOW(a_last_is_pixel, i_clk, i_rst_n, o_out_valid && o_last, o_status == ST_PIXEL, "last flag on a non-pixel result")
    `DLPG_ASSERT_NOW(a_nonpixel_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_PIXEL), (o_pixel_x == '0) && (o_pixel_y == '0) && !o_plot && (o_dot_size == '0) && (o_out_color == '0), "non-pixel result carries data")
    `DLPG_ASSERT_NEXT(a_reset_empties, i_clk, 1'b1, !i_rst_n, !o_out_valid && !w_s1_valid, "registers not empty after reset")

endmodule

// ----- hdl/dlpg_in_stage.sv -----
module dlpg_in_stage #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [COORD_BITS-1:0]           i_start_x,
    input  logic [COORD_BITS-1:0]           i_start_y,
    input  logic [COORD_BITS-1:0]           i_end_x,
    input  logic [COORD_BITS-1:0]           i_end_y,
    input  logic [dlpg_pkg::COLOR_BITS-1:0] i_pen_color,
    input  logic [dlpg_pkg::WIDTH_BITS-1:0] i_pen_width,
    input  logic                            i_dotted,
    input  logic                            i_take,
    output logic                            o_valid,
    output logic                            o_func,
    output logic [COORD_BITS-1:0]           o_start_x,
    output logic [COORD_BITS-1:0]           o_start_y,
    output logic [COORD_BITS-1:0]           o_end_x,
    output logic [COORD_BITS-1:0]           o_end_y,
    output logic [dlpg_pkg::COLOR_BITS-1:0] o_pen_color,
    output logic [dlpg_pkg::WIDTH_BITS-1:0] o_pen_width,
    output logic                            o_dotted
);
    import dlpg_pkg::*;

    logic r_valid;
    logic n_valid;
    logic w_accept;

    assign o_ready  = !r_valid || i_take;
    assign w_accept = i_valid && o_ready;
    assign n_valid  = w_accept || (r_valid && !i_take);
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_func      <= i_func;
            o_start_x   <= i_start_x;
            o_start_y   <= i_start_y;
            o_end_x     <= i_end_x;
            o_end_y     <= i_end_y;
            o_pen_color <= i_pen_color;
            o_pen_width <= i_pen_width;
            o_dotted    <= i_dotted;
        end
    end

endmodule

// ----- hdl/dlpg_core.sv -----
module dlpg_core #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [dlpg_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    input  logic                              i_take,
    input  logic                              i_func,
    input  logic [COORD_BITS-1:0]             i_start_x,
    input  logic [COORD_BITS-1:0]             i_start_y,
    input  logic [COORD_BITS-1:0]             i_end_x,
    input  logic [COORD_BITS-1:0]             i_end_y,
    input  logic [dlpg_pkg::COLOR_BITS-1:0]   i_pen_color,
    input  logic [dlpg_pkg::WIDTH_BITS-1:0]   i_pen_width,
    input  logic                              i_dotted,
    output dlpg_pkg::t_res_ctl                o_ctl,
    output logic [COORD_BITS-1:0]             o_pixel_x,
    output logic [COORD_BITS-1:0]             o_pixel_y,
    output logic [dlpg_pkg::WIDTH_BITS-1:0]   o_dot_size,
    output logic [dlpg_pkg::COLOR_BITS-1:0]   o_out_color
);
    import dlpg_pkg::*;

    localparam int CMAX = (1 << COORD_BITS) - 1;
    localparam logic [COORD_BITS-1:0] DISP_W_INIT =
        COORD_BITS'((DISP_W_RST > CMAX) ? CMAX : DISP_W_RST);
    localparam logic [COORD_BITS-1:0] DISP_H_INIT =
        COORD_BITS'((DISP_H_RST > CMAX) ? CMAX : DISP_H_RST);
    localparam int ERR_BITS = COORD_BITS + 2;

    logic [COORD_BITS-1:0]        r_disp_w, r_disp_h;
    logic [COORD_BITS-1:0]        r_cur_x, r_cur_y, r_tgt_x, r_tgt_y, r_dx;
    logic [COORD_BITS-1:0]        n_cur_x, n_cur_y, n_tgt_x, n_tgt_y, n_dx;
    logic signed [COORD_BITS:0]   r_ndy, n_ndy;
    logic signed [ERR_BITS-1:0]   r_err, n_err;
    logic                         r_sxn, r_syn, n_sxn, n_syn;
    logic [DOT_BITS-1:0]          r_dot_cnt, n_dot_cnt;
    logic                         r_active, n_active;
    logic [WIDTH_BITS-1:0]        r_hw, n_hw;
    logic                         r_hdot, n_hdot;
    logic [COLOR_BITS-1:0]        r_hcol, n_hcol;

    // start decode
    logic                         w_reject;
    logic [COORD_BITS-1:0]        w_sdx, w_sdy;
    // step decode
    logic signed [ERR_BITS:0]     w_e2;
    logic                         w_go_x, w_go_y, w_x_hit, w_y_hit, w_done;
    logic                         w_upd_x, w_upd_y;
    logic signed [ERR_BITS-1:0]   w_err_add_x, w_err_add_y;
    logic [DOT_BITS-1:0]          w_cnt1, w_run, w_gap;
    logic                         w_plot;

    assign w_reject = (i_start_x > r_disp_w) || (i_start_y > r_disp_h) ||
                      (i_end_x > r_disp_w) || (i_end_y > r_disp_h) ||
                      (i_pen_width == '0);
    assign w_sdx = (i_end_x > i_start_x) ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign w_sdy = (i_end_y > i_start_y) ? (i_end_y - i_start_y) : (i_start_y - i_end_y);

    assign w_e2    = {r_err, 1'b0};
    assign w_go_x  = w_e2 >= (ERR_BITS+1)'(r_ndy);
    assign w_go_y  = w_e2 <= $signed({2'b00, r_dx});
    assign w_x_hit = w_go_x && (r_cur_x == r_tgt_x);
    assign w_y_hit = w_go_y && (r_cur_y == r_tgt_y);
    assign w_done  = w_x_hit || w_y_hit;
    assign w_upd_x = w_go_x && !w_x_hit;
    assign w_upd_y = w_go_y && !w_x_hit && !w_y_hit;
    assign w_err_add_x = w_upd_x ? ERR_BITS'(r_ndy) : '0;
    assign w_err_add_y = w_upd_y ? $signed({2'b00, r_dx}) : '0;

    // dotted run: plot below 3w, gap up to 4w, then wrap to zero
    assign w_cnt1 = r_dot_cnt + DOT_BITS'(1);
    assign w_run  = DOT_BITS'(r_hw) * DOT_BITS'(DOT_RUN);
    assign w_gap  = DOT_BITS'(r_hw) * DOT_BITS'(DOT_GAP);
    assign w_plot = !r_hdot || (w_cnt1 < w_run);

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_tgt_x   = r_tgt_x;
        n_tgt_y   = r_tgt_y;
        n_dx      = r_dx;
        n_ndy     = r_ndy;
        n_err     = r_err;
        n_sxn     = r_sxn;
        n_syn     = r_syn;
        n_dot_cnt = r_dot_cnt;
        n_active  = r_active;
        n_hw      = r_hw;
        n_hdot    = r_hdot;
        n_hcol    = r_hcol;
        o_ctl         = '{status: ST_IDLE, plot: 1'b0, last: 1'b0};
        o_pixel_x     = '0;
        o_pixel_y     = '0;
        o_dot_size    = '0;
        o_out_color   = '0;
        if (i_func == FUNC_START) begin
            if (w_reject) begin
                o_ctl.status = ST_REJECT;
                n_active     = 1'b0;
            end else begin
                o_ctl.status = ST_ACCEPT;
                n_cur_x   = i_start_x;
                n_cur_y   = i_start_y;
                n_tgt_x   = i_end_x;
                n_tgt_y   = i_end_y;
                n_dx      = w_sdx;
                n_ndy     = -$signed({1'b0, w_sdy});
                n_err     = $signed({2'b00, w_sdx}) - $signed({2'b00, w_sdy});
                n_sxn     = !(i_start_x < i_end_x);
                n_syn     = !(i_start_y < i_end_y);
                n_dot_cnt = '0;
                n_hw      = i_pen_width;
                n_hdot    = i_dotted;
                n_hcol    = i_pen_color;
                n_active  = 1'b1;
            end
        end else if (r_active) begin
            o_ctl         = '{status: ST_PIXEL, plot: w_plot, last: w_done};
            o_pixel_x     = r_cur_x;
            o_pixel_y     = r_cur_y;
            o_dot_size    = r_hw;
            o_out_color   = r_hcol;
            if (r_hdot) begin
                n_dot_cnt = (w_cnt1 > w_gap) ? '0 : w_cnt1;
            end
            n_err = r_err + w_err_add_x + w_err_add_y;
            if (w_upd_x) begin
                n_cur_x = r_sxn ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
            end
            if (w_upd_y) begin
                n_cur_y = r_syn ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
            end
            if (w_done) begin
                n_active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= DISP_W_INIT;
            r_disp_h <= DISP_H_INIT;
            r_active <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_IDX_WIDTH)) begin
                r_disp_w <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_IDX_HEIGHT)) begin
                r_disp_h <= i_cfg_data;
            end
            if (i_take) begin
                r_active <= n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_tgt_x   <= n_tgt_x;
            r_tgt_y   <= n_tgt_y;
            r_dx      <= n_dx;
            r_ndy     <= n_ndy;
            r_err     <= n_err;
            r_sxn     <= n_sxn;
            r_syn     <= n_syn;
            r_dot_cnt <= n_dot_cnt;
            r_hw      <= n_hw;
            r_hdot    <= n_hdot;
            r_hcol    <= n_hcol;
        end
    end

endmodule

// ----- hdl/dlpg_out_stage.sv -----
module dlpg_out_stage #(
    parameter int COORD_BITS = dlpg_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_take,
    input  dlpg_pkg::t_res_ctl              i_ctl,
    input  logic [COORD_BITS-1:0]           i_pixel_x,
    input  logic [COORD_BITS-1:0]           i_pixel_y,
    input  logic [dlpg_pkg::WIDTH_BITS-1:0] i_dot_size,
    input  logic [dlpg_pkg::COLOR_BITS-1:0] i_out_color,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_status,
    output logic [COORD_BITS-1:0]           o_pixel_x,
    output logic [COORD_BITS-1:0]           o_pixel_y,
    output logic                            o_plot,
    output logic [dlpg_pkg::WIDTH_BITS-1:0] o_dot_size,
    output logic [dlpg_pkg::COLOR_BITS-1:0] o_out_color,
    output logic                            o_last
);
    import dlpg_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_res_ctl r_ctl;

    // load a new result when the register is empty or being drained
    assign o_take  = i_valid && (!r_valid || i_ready);
    assign n_valid = o_take || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ctl         <= i_ctl;
            o_pixel_x     <= i_pixel_x;
            o_pixel_y     <= i_pixel_y;
            o_dot_size    <= i_dot_size;
            o_out_color   <= i_out_color;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_ctl.status;
    assign o_plot   = r_ctl.plot;
    assign o_last   = r_ctl.last;

endmodule
